>>> hw/rtl/json_number_scanner_core_defines.svh
// Assertion macros used by the JSON number scanner RTL.
`ifndef JSON_NUMBER_SCANNER_CORE_DEFINES_SVH
`define JSON_NUMBER_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JNS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JNS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/jns_pkg.sv
// Types and constants of the JSON number scanner.
package jns_pkg;

  localparam int SIG_WIDTH = 64;
  localparam int EXP_WIDTH = 16;
  localparam int NET_WIDTH = EXP_WIDTH + 2;
  localparam int CHAR_WIDTH = 8;

  localparam logic [SIG_WIDTH-1:0] SIG_CAP = {1'b1, {(SIG_WIDTH-1){1'b0}}};
  localparam logic [SIG_WIDTH-1:0] SIG_MAX = {1'b0, {(SIG_WIDTH-1){1'b1}}};
  localparam logic [EXP_WIDTH-1:0] EXP_CAP = {1'b1, {(EXP_WIDTH-1){1'b0}}};
  localparam logic signed [NET_WIDTH-1:0] NET_MAX = {3'b000, {(EXP_WIDTH-1){1'b1}}};
  localparam logic signed [NET_WIDTH-1:0] NET_MIN = {3'b111, {(EXP_WIDTH-1){1'b0}}};

  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_WIDTH-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_WIDTH-1:0] CH_LOW_E = 8'h65;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_E  = 8'h45;

  typedef enum logic [2:0] {
    KIND_INT,
    KIND_SCALED,
    KIND_BADSTART,
    KIND_NOFRAC,
    KIND_NOEXP
  } jns_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_MINUS,
    PH_ZERO,
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_E,
    PH_ESIGN,
    PH_EXP
  } jns_phase_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_in;
    logic                  end_of_text;
  } jns_beat_t;

  typedef struct packed {
    jns_kind_t                    kind;
    logic signed [SIG_WIDTH-1:0]  significand;
    logic signed [EXP_WIDTH-1:0]  dec_exponent;
    logic                         overflowed;
    logic [CHAR_WIDTH-1:0]        stop_char;
    logic                         stopped_at_end;
  } jns_result_t;

endpackage

>>> hw/rtl/jns_if.sv
// Valid/ready channel interfaces for text beats and scanned numbers.
interface jns_text_if;
  logic                           valid;
  logic                           ready;
  logic [jns_pkg::CHAR_WIDTH-1:0] char_in;
  logic                           end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface jns_number_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          kind;
  logic signed [jns_pkg::SIG_WIDTH-1:0] significand;
  logic signed [jns_pkg::EXP_WIDTH-1:0] dec_exponent;
  logic                                overflowed;
  logic [jns_pkg::CHAR_WIDTH-1:0]      stop_char;
  logic                                stopped_at_end;

  modport source (output valid, output kind, output significand, output dec_exponent,
                  output overflowed, output stop_char, output stopped_at_end,
                  input ready);
  modport sink (input valid, input kind, input significand, input dec_exponent,
                input overflowed, input stop_char, input stopped_at_end,
                output ready);
endinterface

>>> hw/rtl/json_number_scanner_core.sv
// Top level of the JSON number scanner.
// Usage:
//   text   : sink channel, one beat per byte (char_in) or an end_of_text
//            marker that ends the current number like any terminator.
//   number : source channel, one beat per finished number: kind, signed
//            significand, decimal exponent, overflow flag and the byte that
//            stopped the scan (not consumed; resend it to start the next token).
//   Throughput: one text beat per cycle unless a second number beat stalls,
//   set by the combinational multiply-by-ten-and-add in the scan stage
//   feeding back into its state. The terminating text beat passes the input
//   register, then the scan logic into the result register.
//   Reset (rst, synchronous): both channels go empty, the scanner returns to
//   waiting for the first character of a number.
//   Stall: while a number beat waits, beats that produce no number still
//   advance; a beat that would produce a second number holds in the input
//   register, and text.ready drops once that register is full.
module json_number_scanner_core (
  input  logic         clk,
  input  logic         rst,
  jns_text_if.sink     text,
  jns_number_if.source number
);
  import jns_pkg::*;

  logic        in_valid;
  jns_beat_t   beat;
  logic        emit;
  logic        slot_free;
  logic        consume;
  jns_result_t res;

  assign consume = in_valid && (!emit || slot_free);

  jns_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .take  (consume),
    .valid (in_valid),
    .beat  (beat)
  );

  jns_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .fire (consume),
    .beat (beat),
    .emit (emit),
    .res  (res)
  );

  jns_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && emit),
    .res       (res),
    .number    (number),
    .slot_free (slot_free)
  );

endmodule

>>> hw/rtl/jns_in_reg.sv
// Input register holding one text beat until the scanner takes it.
module jns_in_reg (
  input  logic               clk,
  input  logic               rst,
  jns_text_if.sink           text,
  input  logic               take,
  output logic               valid,
  output jns_pkg::jns_beat_t beat
);
  import jns_pkg::*;

  logic valid_next;

  assign text.ready = !valid || take;

  always_comb begin
    valid_next = valid;
    if (text.valid && text.ready) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      beat.char_in     <= text.char_in;
      beat.end_of_text <= text.end_of_text;
    end
  end

endmodule

>>> hw/rtl/jns_scan.sv
// Scan state machine: one text beat per cycle while fire is high; a number or error result on the byte that ends it.
`include "json_number_scanner_core_defines.svh"

module jns_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  jns_pkg::jns_beat_t   beat,
  output logic                 emit,
  output jns_pkg::jns_result_t res
);
  import jns_pkg::*;

  jns_phase_t             phase, phase_next;
  logic [SIG_WIDTH-1:0]   magnitude, magnitude_next;
  logic                   negative, negative_next;
  logic [EXP_WIDTH-1:0]   fraction_digits, fraction_digits_next;
  logic [EXP_WIDTH-1:0]   exp_value, exp_value_next;
  logic                   exp_negative, exp_negative_next;
  logic                   sat_flag, sat_flag_next;

  logic [CHAR_WIDTH-1:0]  c;
  logic [CHAR_WIDTH-1:0]  c_off;
  logic [3:0]             digit;
  logic                   is_digit, is_e, is_dot, is_minus, is_plus;

  logic [SIG_WIDTH+3:0]   mag_wide, mag_mul;
  logic                   mag_over;
  logic [SIG_WIDTH-1:0]   mag_digit;
  logic [EXP_WIDTH+3:0]   exp_wide, exp_mul;
  logic                   exp_over;
  logic [EXP_WIDTH-1:0]   exp_digit;
  logic                   frac_over;
  logic [EXP_WIDTH-1:0]   frac_inc;

  logic [SIG_WIDTH-1:0]   sig_val;
  logic                   sig_clamp;
  logic signed [NET_WIDTH-1:0] exp_s, net_raw, net_val;
  logic                   net_clamp;

  logic                   has_err;
  jns_kind_t              err_kind;

  assign c        = beat.end_of_text ? '0 : beat.char_in;
  assign c_off    = c - CH_ZERO;
  assign digit    = c_off[3:0];
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_e     = (c == CH_LOW_E) || (c == CH_UP_E);
  assign is_dot   = (c == CH_DOT);
  assign is_minus = (c == CH_MINUS);
  assign is_plus  = (c == CH_PLUS);

  assign mag_wide  = {4'b0000, magnitude};
  assign mag_mul   = (mag_wide << 3) + (mag_wide << 1) + {{SIG_WIDTH{1'b0}}, digit};
  assign mag_over  = mag_mul > {4'b0000, SIG_CAP};
  assign mag_digit = mag_over ? SIG_CAP : mag_mul[SIG_WIDTH-1:0];

  assign exp_wide  = {4'b0000, exp_value};
  assign exp_mul   = (exp_wide << 3) + (exp_wide << 1) + {{EXP_WIDTH{1'b0}}, digit};
  assign exp_over  = exp_mul > {4'b0000, EXP_CAP};
  assign exp_digit = exp_over ? EXP_CAP : exp_mul[EXP_WIDTH-1:0];

  assign frac_over = fraction_digits >= EXP_CAP;
  assign frac_inc  = frac_over ? EXP_CAP
                               : fraction_digits + {{(EXP_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    sig_clamp = 1'b0;
    if (negative) begin
      sig_val = '0 - magnitude;
    end else if (magnitude > SIG_MAX) begin
      sig_val   = SIG_MAX;
      sig_clamp = 1'b1;
    end else begin
      sig_val = magnitude;
    end
  end

  always_comb begin
    exp_s = signed'({2'b00, exp_value});
    if (exp_negative) begin
      exp_s = -exp_s;
    end
    net_raw   = exp_s - signed'({2'b00, fraction_digits});
    net_clamp = 1'b0;
    net_val   = net_raw;
    if (net_raw > NET_MAX) begin
      net_val   = NET_MAX;
      net_clamp = 1'b1;
    end else if (net_raw < NET_MIN) begin
      net_val   = NET_MIN;
      net_clamp = 1'b1;
    end
  end

  always_comb begin
    phase_next           = phase;
    magnitude_next       = magnitude;
    negative_next        = negative;
    fraction_digits_next = fraction_digits;
    exp_value_next       = exp_value;
    exp_negative_next    = exp_negative;
    sat_flag_next        = sat_flag;
    emit                 = 1'b0;
    has_err              = 1'b0;
    err_kind             = KIND_BADSTART;
    case (phase)
      PH_IDLE, PH_MINUS: begin
        if (phase == PH_IDLE && is_minus) begin
          negative_next = 1'b1;
          phase_next    = PH_MINUS;
        end else if (is_digit) begin
          magnitude_next = {{(SIG_WIDTH-4){1'b0}}, digit};
          phase_next     = (digit == 4'd0) ? PH_ZERO : PH_INT;
        end else begin
          emit    = 1'b1;
          has_err = 1'b1;
        end
      end
      PH_ZERO, PH_INT: begin
        if (is_digit && phase == PH_INT) begin
          magnitude_next = mag_digit;
          sat_flag_next  = sat_flag | mag_over;
        end else if (is_dot) begin
          phase_next = PH_DOT;
        end else if (is_e) begin
          phase_next = PH_E;
        end else begin
          emit = 1'b1;
        end
      end
      PH_DOT, PH_FRAC: begin
        if (is_digit) begin
          magnitude_next       = mag_digit;
          fraction_digits_next = frac_inc;
          sat_flag_next        = sat_flag | mag_over | frac_over;
          phase_next           = PH_FRAC;
        end else if (phase == PH_DOT) begin
          emit     = 1'b1;
          has_err  = 1'b1;
          err_kind = KIND_NOFRAC;
        end else if (is_e) begin
          phase_next = PH_E;
        end else begin
          emit = 1'b1;
        end
      end
      PH_E, PH_ESIGN, PH_EXP: begin
        if (phase == PH_E && (is_minus || is_plus)) begin
          exp_negative_next = is_minus;
          phase_next        = PH_ESIGN;
        end else if (is_digit) begin
          exp_value_next = exp_digit;
          sat_flag_next  = sat_flag | exp_over;
          phase_next     = PH_EXP;
        end else begin
          emit = 1'b1;
          if (phase != PH_EXP) begin
            has_err  = 1'b1;
            err_kind = KIND_NOEXP;
          end
        end
      end
      default: begin
        emit    = 1'b1;
        has_err = 1'b1;
      end
    endcase
    if (emit) begin
      phase_next           = PH_IDLE;
      magnitude_next       = '0;
      negative_next        = 1'b0;
      fraction_digits_next = '0;
      exp_value_next       = '0;
      exp_negative_next    = 1'b0;
      sat_flag_next        = 1'b0;
    end
  end

  always_comb begin
    res.stop_char      = c;
    res.stopped_at_end = beat.end_of_text;
    if (has_err) begin
      res.kind         = err_kind;
      res.significand  = '0;
      res.dec_exponent = '0;
      res.overflowed   = 1'b0;
    end else begin
      res.kind         = (net_val == '0) ? KIND_INT : KIND_SCALED;
      res.significand  = signed'(sig_val);
      res.dec_exponent = net_val[EXP_WIDTH-1:0];
      res.overflowed   = sat_flag | sig_clamp | net_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      magnitude       <= '0;
      negative        <= 1'b0;
      fraction_digits <= '0;
      exp_value       <= '0;
      exp_negative    <= 1'b0;
      sat_flag        <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      magnitude       <= magnitude_next;
      negative        <= negative_next;
      fraction_digits <= fraction_digits_next;
      exp_value       <= exp_value_next;
      exp_negative    <= exp_negative_next;
      sat_flag        <= sat_flag_next;
    end
  end

  `JNS_ASSERT_NXT(a_idle_after_result, clk, rst, fire && emit,
    phase == PH_IDLE && magnitude == '0 && !sat_flag, "state not cleared after result")
  `JNS_ASSERT_IMP(a_error_fields_zero, clk, rst, emit && has_err,
    res.significand == '0 && res.dec_exponent == '0 && !res.overflowed,
    "error result carries number fields")
  `JNS_ASSERT_IMP(a_int_has_no_exponent, clk, rst, emit && res.kind == KIND_INT,
    res.dec_exponent == '0, "integer result with nonzero exponent")
  `JNS_ASSERT_IMP(a_counts_capped, clk, rst, 1'b1,
    fraction_digits <= EXP_CAP && exp_value <= EXP_CAP && magnitude <= SIG_CAP,
    "accumulator beyond saturation cap")

endmodule

>>> hw/rtl/jns_out_reg.sv
// Result register driving the number channel.
module jns_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  jns_pkg::jns_result_t res,
  jns_number_if.source         number,
  output logic                 slot_free
);
  import jns_pkg::*;

  logic        valid, valid_next;
  jns_result_t held;

  assign slot_free = !valid || number.ready;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (number.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign number.valid          = valid;
  assign number.kind           = held.kind;
  assign number.significand    = held.significand;
  assign number.dec_exponent   = held.dec_exponent;
  assign number.overflowed     = held.overflowed;
  assign number.stop_char      = held.stop_char;
  assign number.stopped_at_end = held.stopped_at_end;

endmodule
